### src/dtdn_pkg.sv
package dtdn_pkg;

  // field widths
  localparam int YEAR_W   = 19;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DAYS_W   = 27;
  localparam int MONTHS_W = 22;
  localparam int WDAY_W   = 3;
  localparam int CUM_W    = 9;

  // largest year accepted by default
  localparam int unsigned MAX_YEAR = 292451;

  // year / 100 by reciprocal: floor(year * CENT_RECIP / 2^CENT_SHIFT)
  localparam int RECIP_W    = 20;
  localparam int PROD_W     = YEAR_W + RECIP_W;
  localparam int CENT_SHIFT = 26;
  localparam int CENT_W     = 13;
  localparam logic [RECIP_W-1:0] CENT_RECIP = 20'd671089;

  // calendar switch and the first century adjustment
  localparam logic [YEAR_W-1:0]  SWITCH_YEAR     = 19'd1752;
  localparam logic [MONTH_W-1:0] SWITCH_MONTH    = 4'd9;
  localparam logic [DAY_W-1:0]   LAST_JULIAN_DAY = 5'd2;
  localparam logic [DAY_W-1:0]   FIRST_GAP_DAY   = 5'd3;
  localparam logic [DAY_W-1:0]   LAST_GAP_DAY    = 5'd13;
  localparam logic [YEAR_W-1:0]  REFORM_YEAR     = 19'd1800;
  localparam logic [MONTH_W-1:0] REFORM_MONTH    = 4'd3;
  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [CUM_W-1:0]   DAYS_PER_YEAR   = 9'd365;

  // zero-based month codes
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_MAY = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUL = 4'd6;
  localparam logic [MONTH_W-1:0] MON_AUG = 4'd7;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd8;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd10;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd11;

  typedef struct packed {
    logic               bc_era;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // after the century divide
  typedef struct packed {
    date_t             date;
    logic [CENT_W-1:0] cent;
  } s1_t;

  // after the validity check
  typedef struct packed {
    logic               ok;
    logic               bc;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] mon0;
    logic [DAY_W-1:0]   day;
    logic [CENT_W-1:0]  cent;
    logic               rem_zero;
    logic               after;
    logic               ge_reform;
    logic [CUM_W-1:0]   cum;
  } s2_t;

  // after the day count
  typedef struct packed {
    logic                ok;
    logic                bc;
    logic [DAYS_W-1:0]   days;
    logic [MONTHS_W-1:0] months;
  } s3_t;

  // result word
  typedef struct packed {
    logic [DAYS_W-1:0]   elapsed_days;
    logic [MONTHS_W-1:0] elapsed_months;
    logic [WDAY_W-1:0]   weekday;
    logic                date_valid;
  } res_t;

  // days in a zero-based month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    case (m)
      MON_FEB: return leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  // days before a zero-based month in a common year
  function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    case (m)
      MON_JAN: return 9'd0;
      MON_FEB: return 9'd31;
      MON_MAR: return 9'd59;
      MON_APR: return 9'd90;
      MON_MAY: return 9'd120;
      MON_JUN: return 9'd151;
      MON_JUL: return 9'd181;
      MON_AUG: return 9'd212;
      MON_SEP: return 9'd243;
      MON_OCT: return 9'd273;
      MON_NOV: return 9'd304;
      MON_DEC: return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  // x mod 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [WDAY_W-1:0] mod7(input logic [DAYS_W-1:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 0; i < DAYS_W / 3; i++) begin
      s1 = s1 + 6'(x[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = s2[2:0] + 3'(s2[3]);
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

### src/dtdn_in_if.sv
interface dtdn_in_if;
  logic                          valid;
  logic                          ready;
  logic                          bc_era;
  logic [dtdn_pkg::YEAR_W-1:0]   year;
  logic [dtdn_pkg::MONTH_W-1:0]  month;
  logic [dtdn_pkg::DAY_W-1:0]    day;

  modport source (output valid, bc_era, year, month, day, input ready);
  modport sink (input valid, bc_era, year, month, day, output ready);
endinterface

### src/dtdn_out_if.sv
interface dtdn_out_if;
  logic                            valid;
  logic                            ready;
  logic [dtdn_pkg::DAYS_W-1:0]     elapsed_days;
  logic [dtdn_pkg::MONTHS_W-1:0]   elapsed_months;
  logic [dtdn_pkg::WDAY_W-1:0]     weekday;
  logic                            date_valid;

  modport source (output valid, elapsed_days, elapsed_months, weekday, date_valid,
                  input ready);
  modport sink (input valid, elapsed_days, elapsed_months, weekday, date_valid,
                output ready);
endinterface

### src/dtdn_divide.sv
module dtdn_divide (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  dtdn_pkg::date_t in_data,
  output logic            out_valid,
  output dtdn_pkg::s1_t   out_data
);

  logic [dtdn_pkg::PROD_W-1:0] prod;

  // century number by reciprocal multiply
  assign prod = dtdn_pkg::PROD_W'(in_data.year) * dtdn_pkg::PROD_W'(dtdn_pkg::CENT_RECIP);

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.date <= in_data;
      out_data.cent <= prod[dtdn_pkg::CENT_SHIFT +: dtdn_pkg::CENT_W];
    end
  end

endmodule

### src/dtdn_check.sv
module dtdn_check #(
  parameter int unsigned MAX_YEAR = dtdn_pkg::MAX_YEAR
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  dtdn_pkg::s1_t in_data,
  output logic          out_valid,
  output dtdn_pkg::s2_t out_data
);

  logic [dtdn_pkg::YEAR_W-1:0]  year;
  logic [dtdn_pkg::MONTH_W-1:0] month;
  logic [dtdn_pkg::DAY_W-1:0]   day;
  logic [dtdn_pkg::MONTH_W-1:0] mon0;
  logic [dtdn_pkg::YEAR_W-1:0]  rem;
  logic                         rem_zero;
  logic                         div400;
  logic                         on_switch_month;
  logic                         after;
  logic                         gap;
  logic                         ge_reform;
  logic                         leap;
  logic                         in_range;
  logic                         ok;

  assign year  = in_data.date.year;
  assign month = in_data.date.month;
  assign day   = in_data.date.day;
  assign mon0  = month - 4'd1;

  // year mod 100 from the century number
  assign rem      = year - dtdn_pkg::YEAR_W'(20'(in_data.cent) * 20'd100);
  assign rem_zero = (rem == '0);
  assign div400   = rem_zero && (in_data.cent[1:0] == 2'd0);

  // position relative to the calendar switch
  assign on_switch_month = (year == dtdn_pkg::SWITCH_YEAR) && (month == dtdn_pkg::SWITCH_MONTH);
  assign after = !in_data.date.bc_era &&
                 ((year > dtdn_pkg::SWITCH_YEAR) ||
                  ((year == dtdn_pkg::SWITCH_YEAR) && (month > dtdn_pkg::SWITCH_MONTH)) ||
                  (on_switch_month && (day > dtdn_pkg::LAST_JULIAN_DAY)));
  assign ge_reform = (year > dtdn_pkg::REFORM_YEAR) ||
                     ((year == dtdn_pkg::REFORM_YEAR) && (month >= dtdn_pkg::REFORM_MONTH));

  // leap year and range checks
  always_comb begin
    gap = !in_data.date.bc_era && on_switch_month &&
          (day inside {[dtdn_pkg::FIRST_GAP_DAY:dtdn_pkg::LAST_GAP_DAY]});
    if (!after) begin
      leap = in_data.date.bc_era ? (year[1:0] == 2'd1) : (year[1:0] == 2'd0);
    end else begin
      leap = (year[1:0] == 2'd0) && (!rem_zero || div400);
    end
    in_range = (day != '0) && (year != '0) && (32'(year) <= MAX_YEAR) &&
               (month inside {[4'd1:dtdn_pkg::MONTHS_PER_YEAR]});
    ok = in_range && !gap && (day <= dtdn_pkg::month_len(mon0, leap));
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.ok        <= ok;
      out_data.bc        <= in_data.date.bc_era;
      out_data.year      <= year;
      out_data.mon0      <= mon0;
      out_data.day       <= day;
      out_data.cent      <= in_data.cent;
      out_data.rem_zero  <= rem_zero;
      out_data.after     <= after;
      out_data.ge_reform <= ge_reform;
      out_data.cum       <= dtdn_pkg::cum_days(mon0);
    end
  end

endmodule

### src/dtdn_count.sv
module dtdn_count (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  dtdn_pkg::s2_t in_data,
  output logic          out_valid,
  output dtdn_pkg::s3_t out_data
);

  localparam int DW = dtdn_pkg::DAYS_W;
  localparam int MW = dtdn_pkg::MONTHS_W;

  logic [dtdn_pkg::CUM_W-1:0]  t0;
  logic [dtdn_pkg::CUM_W-1:0]  tin;
  logic [dtdn_pkg::YEAR_W-1:0] ym1;
  logic [DW-1:0]               base;
  logic [DW-1:0]               leap_days;
  logic                        early;
  logic                        b;
  logic                        cent_leap_case;
  logic [DW-1:0]               corr;
  logic [DW-1:0]               greg;
  logic [DW-1:0]               days;
  logic [dtdn_pkg::MONTH_W-1:0] mon_off;
  logic [MW-1:0]               months;

  assign early = (in_data.mon0 == dtdn_pkg::MON_JAN) || (in_data.mon0 == dtdn_pkg::MON_FEB);
  assign ym1   = in_data.year - 19'd1;

  // day within the year, counted back for BC
  assign t0   = in_data.cum + dtdn_pkg::CUM_W'(in_data.day) - 9'd1;
  assign tin  = in_data.bc ? dtdn_pkg::DAYS_PER_YEAR - t0 : t0;
  assign base = DW'(ym1) * DW'(dtdn_pkg::DAYS_PER_YEAR);

  // julian leap days
  always_comb begin
    if (in_data.bc) begin
      leap_days = (in_data.year >= 19'd2) ? DW'((in_data.year - 19'd2) >> 2) + 27'd1 : '0;
      leap_days = leap_days + DW'(early && (in_data.year[1:0] == 2'd1));
    end else begin
      leap_days = DW'(ym1 >> 2) + DW'(!early && (in_data.year[1:0] == 2'd0));
    end
  end

  // gregorian correction: dropped days, century rule, 400 year rule
  always_comb begin
    cent_leap_case = early && in_data.rem_zero;
    b = !(cent_leap_case && (in_data.cent[1:0] == 2'd0));
    if (cent_leap_case) begin
      corr = DW'(in_data.cent) - 27'd18;
    end else if (in_data.ge_reform) begin
      corr = DW'(in_data.cent) - 27'd17;
    end else begin
      corr = '0;
    end
    greg = DW'(in_data.cent >> 2) + DW'(b) - 27'd16 - corr;
  end

  assign days    = base + DW'(tin) + leap_days + (in_data.after ? greg : '0);
  assign mon_off = in_data.bc ? dtdn_pkg::MONTHS_PER_YEAR - in_data.mon0 : in_data.mon0;
  assign months  = MW'(ym1) * MW'(dtdn_pkg::MONTHS_PER_YEAR) + MW'(mon_off);

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // stage payload, zeroed for a date that does not exist
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.ok     <= in_data.ok;
      out_data.bc     <= in_data.bc;
      out_data.days   <= in_data.ok ? days : '0;
      out_data.months <= in_data.ok ? months : '0;
    end
  end

endmodule

### src/dtdn_weekday.sv
module dtdn_weekday (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  dtdn_pkg::s3_t  in_data,
  output logic           out_valid,
  output dtdn_pkg::res_t out_data
);

  logic [dtdn_pkg::WDAY_W-1:0] r;
  logic [dtdn_pkg::WDAY_W-1:0] wd;

  // weekday runs backward for BC dates
  assign r  = dtdn_pkg::mod7(in_data.days);
  assign wd = (in_data.bc && (r != '0)) ? 3'd7 - r : r;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.elapsed_days   <= in_data.days;
      out_data.elapsed_months <= in_data.months;
      out_data.weekday        <= wd;
      out_data.date_valid     <= in_data.ok;
    end
  end

endmodule

### src/date_to_day_number.sv
// stages in order: divide, check, count, weekday
// one word per cycle unless stalled; four register stages with a valid bit each
// each stage advances when it is empty or the stage after it advances
// reset (rst, synchronous) clears the stage valid bits; no other state
module date_to_day_number #(
  parameter int unsigned MAX_YEAR = dtdn_pkg::MAX_YEAR
) (
  input logic         clk,
  input logic         rst,
  dtdn_in_if.sink     date,
  dtdn_out_if.source  result
);

  dtdn_pkg::date_t in_data;
  dtdn_pkg::s1_t   s1_data;
  dtdn_pkg::s2_t   s2_data;
  dtdn_pkg::s3_t   s3_data;
  dtdn_pkg::res_t  res_data;
  logic            v1, v2, v3, v4;
  logic            en1, en2, en3, en4;

  // stall chain from the output back
  assign en4 = !v4 || result.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign date.ready = en1;

  assign in_data.bc_era = date.bc_era;
  assign in_data.year   = date.year;
  assign in_data.month  = date.month;
  assign in_data.day    = date.day;

  dtdn_divide u_divide (
    .clk(clk), .rst(rst), .en(en1), .in_valid(date.valid), .in_data(in_data),
    .out_valid(v1), .out_data(s1_data)
  );

  dtdn_check #(.MAX_YEAR(MAX_YEAR)) u_check (
    .clk(clk), .rst(rst), .en(en2), .in_valid(v1), .in_data(s1_data),
    .out_valid(v2), .out_data(s2_data)
  );

  dtdn_count u_count (
    .clk(clk), .rst(rst), .en(en3), .in_valid(v2), .in_data(s2_data),
    .out_valid(v3), .out_data(s3_data)
  );

  dtdn_weekday u_weekday (
    .clk(clk), .rst(rst), .en(en4), .in_valid(v3), .in_data(s3_data),
    .out_valid(v4), .out_data(res_data)
  );

  // result word
  assign result.valid          = v4;
  assign result.elapsed_days   = res_data.elapsed_days;
  assign result.elapsed_months = res_data.elapsed_months;
  assign result.weekday        = res_data.weekday;
  assign result.date_valid     = res_data.date_valid;

endmodule

### src/dtdn_checker.sv
module dtdn_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dtdn_pkg::DAYS_W-1:0]     days,
  input logic [dtdn_pkg::MONTHS_W-1:0]   months,
  input logic [dtdn_pkg::WDAY_W-1:0]     weekday,
  input logic                            date_valid
);

  // pipeline is empty and open right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(days) && $stable(months) && $stable(weekday) &&
       $stable(date_valid)))
    else $error("stalled result word changed");

  // a date that does not exist gives zero counts
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !date_valid) |-> (days == '0 && months == '0 && weekday == '0))
    else $error("invalid date gave nonzero counts");

  // weekday code stays in range
  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weekday <= 3'd6))
    else $error("weekday out of range");

endmodule

bind date_to_day_number dtdn_checker u_dtdn_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(date.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .days(result.elapsed_days),
  .months(result.elapsed_months),
  .weekday(result.weekday),
  .date_valid(result.date_valid)
);
